>>> design/fmbq_pkg.sv
// Shared types and constants of the front/middle/back queue.
`timescale 1ns / 1ps
package fmbq_pkg;

  // Queue size and derived widths
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int RING_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int RING_D   = 1 << RING_W;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_BALANCE,
    S_MOVE,
    S_DELIVER
  } state_t;

endpackage

>>> design/fmbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fmbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/front_middle_back_queue_core.sv
// Top level of the front/middle/back queue: two ring halves and their sequencer.
//
// Usage:
//   The slave channel takes one request per handshake: s_tuser carries the
//   operation (push front, middle or back; pop front, middle or back) and
//   s_tdata the value to push. The master channel returns one result per
//   request: m_tdata holds the popped value (zero otherwise) and m_tuser the
//   status (done, pop on empty, push on full dropped).
//   The queue is kept as two halves, each a ring in its own RAM: the front
//   half holds floor(n/2) entries, the back half the rest, so every operation
//   touches only the ends of a half. After the operation at most one entry
//   moves across to restore the balance.
//   Sequence: a push writes its half and goes to the balancing step; a pop
//   first takes its value from the registered RAM read; a failed or unknown
//   request goes straight to delivery. A balancing move reads one half's RAM
//   and writes the other. One request is worked on at a time; s_tready is high only between requests.
//   Reset empties the queue at once; RAM contents are never read before they
//   are written. A stalled receiver holds the result in the output register;
//   the next request is still accepted and waits for the register to free.
`timescale 1ns / 1ps
module front_middle_back_queue_core
  import fmbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] push_value
  input  logic [2:0]        s_tuser,   // [2:0] opcode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [31:0] pop_value
  output logic [1:0]        m_tuser    // [1:0] status
);

  state_t              state, state_next;
  logic [RING_W-1:0]   fhead, fhead_next, bhead, bhead_next;
  logic [CNT_W-1:0]    fcnt, fcnt_next, bcnt, bcnt_next;
  logic [DATA_W-1:0]   res_value, res_value_next;
  status_t             res_status, res_status_next;
  logic                rd_back, rd_back_next;
  logic                to_back, to_back_next;
  logic                m_tvalid_next;
  logic [DATA_W-1:0]   m_tdata_next;
  logic [1:0]          m_tuser_next;

  logic                f_we, b_we;
  logic [RING_W-1:0]   f_waddr, f_raddr, b_waddr, b_raddr;
  logic [DATA_W-1:0]   f_wdata, b_wdata, f_rdata, b_rdata;

  logic [CNT_W-1:0]    n, target;

  assign n        = fcnt + bcnt;
  assign target   = n >> 1;
  assign s_tready = (state == S_IDLE);

  fmbq_ram #(.WIDTH(DATA_W), .DEPTH(RING_D)) u_front (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  fmbq_ram #(.WIDTH(DATA_W), .DEPTH(RING_D)) u_back (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fhead    <= '0;
      bhead    <= '0;
      fcnt     <= '0;
      bcnt     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fhead    <= fhead_next;
      bhead    <= bhead_next;
      fcnt     <= fcnt_next;
      bcnt     <= bcnt_next;
      m_tvalid <= m_tvalid_next;
    end
    res_value  <= res_value_next;
    res_status <= res_status_next;
    rd_back    <= rd_back_next;
    to_back    <= to_back_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

  // Sequence each request: primary access, pop read, rebalance, deliver
  always_comb begin
    state_next      = state;
    fhead_next      = fhead;
    bhead_next      = bhead;
    fcnt_next       = fcnt;
    bcnt_next       = bcnt;
    res_value_next  = res_value;
    res_status_next = res_status;
    rd_back_next    = rd_back;
    to_back_next    = to_back;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    f_we    = 1'b0;
    b_we    = 1'b0;
    f_waddr = fhead;
    b_waddr = bhead;
    f_wdata = s_tdata;
    b_wdata = s_tdata;
    f_raddr = fhead;
    b_raddr = bhead;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          res_value_next  = '0;
          res_status_next = ST_DONE;
          state_next      = S_DELIVER;
          case (s_tuser)
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
              if (n == CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
              end else begin
                state_next = S_BALANCE;
                if (s_tuser == OP_PUSH_FRONT) begin
                  f_we       = 1'b1;
                  f_waddr    = fhead - 1'b1;
                  fhead_next = fhead - 1'b1;
                  fcnt_next  = fcnt + 1'b1;
                end else if (s_tuser == OP_PUSH_MIDDLE) begin
                  b_we       = 1'b1;
                  b_waddr    = bhead - 1'b1;
                  bhead_next = bhead - 1'b1;
                  bcnt_next  = bcnt + 1'b1;
                end else begin
                  b_we      = 1'b1;
                  b_waddr   = bhead + RING_W'(bcnt);
                  bcnt_next = bcnt + 1'b1;
                end
              end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
              if (n == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                state_next = S_POP;
                if (s_tuser == OP_POP_FRONT && fcnt != '0) begin
                  rd_back_next = 1'b0;
                  f_raddr      = fhead;
                  fhead_next   = fhead + 1'b1;
                  fcnt_next    = fcnt - 1'b1;
                end else if (s_tuser == OP_POP_MIDDLE && !n[0]) begin
                  rd_back_next = 1'b0;
                  f_raddr      = fhead + RING_W'(fcnt) - 1'b1;
                  fcnt_next    = fcnt - 1'b1;
                end else if (s_tuser == OP_POP_BACK) begin
                  rd_back_next = 1'b1;
                  b_raddr      = bhead + RING_W'(bcnt) - 1'b1;
                  bcnt_next    = bcnt - 1'b1;
                end else begin
                  rd_back_next = 1'b1;
                  b_raddr      = bhead;
                  bhead_next   = bhead + 1'b1;
                  bcnt_next    = bcnt - 1'b1;
                end
              end
            end
            default: begin
              res_status_next = ST_DONE;
            end
          endcase
        end
      end
      S_POP: begin
        res_value_next = rd_back ? b_rdata : f_rdata;
        state_next     = S_BALANCE;
      end
      S_BALANCE: begin
        if (fcnt > target) begin
          // Drop the last front entry and carry it to the back head
          to_back_next = 1'b1;
          f_raddr      = fhead + RING_W'(fcnt) - 1'b1;
          fcnt_next    = fcnt - 1'b1;
          state_next   = S_MOVE;
        end else if (fcnt < target) begin
          // Take the back head and append it to the front half
          to_back_next = 1'b0;
          b_raddr      = bhead;
          bhead_next   = bhead + 1'b1;
          bcnt_next    = bcnt - 1'b1;
          state_next   = S_MOVE;
        end else begin
          state_next = S_DELIVER;
        end
      end
      S_MOVE: begin
        if (to_back) begin
          b_we       = 1'b1;
          b_waddr    = bhead - 1'b1;
          b_wdata    = f_rdata;
          bhead_next = bhead - 1'b1;
          bcnt_next  = bcnt + 1'b1;
        end else begin
          f_we      = 1'b1;
          f_waddr   = fhead + RING_W'(fcnt);
          f_wdata   = b_rdata;
          fcnt_next = fcnt + 1'b1;
        end
        state_next = S_DELIVER;
      end
      S_DELIVER: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = res_value;
          m_tuser_next  = res_status;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> tb/fmbq_checker.sv
// Checker for the front/middle/back queue: predicts each result and compares.
`timescale 1ns / 1ps
module fmbq_checker
  import fmbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic [2:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DATA_W-1:0] m_tdata,
  input  logic [1:0]        m_tuser,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
  } outcome_t;

  logic [DATA_W-1:0] shadow_q[$];
  outcome_t          outcome_q[$];

  assign pending = outcome_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Apply one request to the shadow queue and give its outcome
  function automatic outcome_t apply_request(input logic [2:0] op, input logic [DATA_W-1:0] v);
    outcome_t r;
    int n;
    int pos;
    n = shadow_q.size();
    r.value = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else begin
          pos = (op == OP_PUSH_FRONT) ? 0 : (op == OP_PUSH_MIDDLE) ? n / 2 : n;
          shadow_q.insert(pos, v);
        end
      end
      OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else begin
          pos = (op == OP_POP_FRONT) ? 0 : (op == OP_POP_MIDDLE) ? (n - 1) / 2 : n - 1;
          r.value = shadow_q[pos];
          shadow_q.delete(pos);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      errors <= 0;
      shadow_q.delete();
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) report("result with nothing expected");
        else begin
          want = outcome_q.pop_front();
          got.value = m_tdata;
          got.status = status_t'(m_tuser);
          if (got.value !== want.value)
            report($sformatf("pop_value %h, expected %h", got.value, want.value));
          if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
      if (s_tvalid && s_tready) outcome_q.push_back(apply_request(s_tuser, s_tdata));
    end
  end

endmodule

>>> tb/tb_front_middle_back_queue_core.sv
// Testbench top: drives requests to the queue and gives the verdict.
`timescale 1ns / 1ps
module tb_front_middle_back_queue_core;
  import fmbq_pkg::*;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;
  logic [2:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  int                errors;
  int                pending;

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;

  front_middle_back_queue_core dut (.*);

  fmbq_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one request; random idle cycles come before it
  task automatic send_request(input logic [2:0] op, input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Bias pushes or pops so the queue sweeps between empty and full
  task automatic random_phase(input int count, input int push_pct);
    logic [2:0] op;
    repeat (count) begin
      if ($urandom_range(99) < 2) op = 3'($urandom_range(7, 6));
      else if ($urandom_range(99) < push_pct) op = 3'($urandom_range(2));
      else op = 3'($urandom_range(5, 3));
      send_request(op, random_value());
    end
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pops on empty, every push, extremes, every pop, unknown codes
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_MIDDLE, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 32'h7fff_ffff);
    send_request(OP_PUSH_MIDDLE, 32'hffff_ffff);
    send_request(OP_PUSH_MIDDLE, 32'h0000_0001);
    send_request(3'd6, 32'h5555_5555);
    send_request(3'd7, 32'haaaa_aaaa);
    send_request(OP_POP_MIDDLE, '1);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_MIDDLE, '0);
    send_request(OP_POP_MIDDLE, '0);

    // Pause until all results are back
    drain_wait();

    // Fill past capacity with the receiver held off
    hold_off_cycles <= 400;
    repeat (CAPACITY + 3) send_request(3'($urandom_range(2)), random_value());
    drain_wait();
    repeat (CAPACITY + 2) send_request(3'($urandom_range(5, 3)), '0);

    // Idling phases: none, sender, receiver, both, then none again
    random_phase(60, 60);
    send_idle_pct = 88;
    random_phase(60, 40);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    random_phase(60, 80);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_phase(70, 30);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(50, 90);
    drain_wait();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
